### rtl/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Types and constants shared by the CSV line field tokenizer modules.
// ----------------------------------------------------------------------------
package csvt_pkg;

  localparam int IDX_W = 6;
  localparam int OFS_W = 13;
  localparam int CNT_W = 7;
  localparam int MAXF_W = 7;

  localparam logic [MAXF_W-1:0] MAXF_RESET = 7'd64;

  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  typedef enum logic [2:0] {
    PH_LINE_START  = 3'd0,
    PH_FIELD_START = 3'd1,
    PH_UNQUOTED    = 3'd2,
    PH_QUOTED      = 3'd3,
    PH_QUOTE_SEEN  = 3'd4,
    PH_FAILED      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FIELD  = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_NONE         = 3'd0,
    CAUSE_CAPACITY     = 3'd1,
    CAUSE_STRAY        = 3'd2,
    CAUSE_JUNK         = 3'd3,
    CAUSE_UNTERMINATED = 3'd4,
    CAUSE_TOO_LONG     = 3'd5
  } cause_t;

  // Up to one field record and one line status record from one item
  typedef struct packed {
    logic             fld_v;
    logic [IDX_W-1:0] fidx;
    logic [OFS_W-1:0] fbegin;
    logic [OFS_W-1:0] fend;
    logic             quoted;
    logic [CNT_W-1:0] fcnt;
    logic             sts_v;
    kind_t            kind;
    logic [CNT_W-1:0] scnt;
    cause_t           cause;
  } rec_pair_t;

  typedef struct packed {
    kind_t            kind;
    logic [IDX_W-1:0] fidx;
    logic [OFS_W-1:0] fbegin;
    logic [OFS_W-1:0] fend;
    logic             quoted;
    logic [CNT_W-1:0] cnt;
    cause_t           cause;
    logic             last;
  } out_rec_t;

endpackage

### rtl/csvt_in_if.sv
// ----------------------------------------------------------------------------
// csvt_in_if
// Input channel: one line byte or an end-of-line marker per transfer.
// ----------------------------------------------------------------------------
interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_byte;

  modport source (output valid, output mode, output char_byte, input ready);
  modport sink (input valid, input mode, input char_byte, output ready);
endinterface

### rtl/csvt_out_if.sv
// ----------------------------------------------------------------------------
// csvt_out_if
// Result channel: field records and line status records.
// ----------------------------------------------------------------------------
interface csvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  record_kind;
  logic [5:0]  field_index;
  logic [12:0] field_begin;
  logic [12:0] field_end;
  logic        field_quoted;
  logic [6:0]  fields_in_line;
  logic [2:0]  error_cause;
  logic        last_of_run;

  modport source (
    output valid, output record_kind, output field_index, output field_begin,
    output field_end, output field_quoted, output fields_in_line,
    output error_cause, output last_of_run, input ready
  );
  modport sink (
    input valid, input record_kind, input field_index, input field_begin,
    input field_end, input field_quoted, input fields_in_line,
    input error_cause, input last_of_run, output ready
  );
endinterface

### rtl/csvt_front.sv
// ----------------------------------------------------------------------------
// csvt_front
// Parser front end: takes one byte or end-of-line item per cycle unless the
// queue is full, updates the parse state and builds the records it causes.
// ----------------------------------------------------------------------------
module csvt_front #(
  parameter int MAX_LINE    = 4096,
  parameter int FIELD_LIMIT = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_char,
  input  logic                          cfg_we,
  input  logic [csvt_pkg::MAXF_W-1:0]   cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output csvt_pkg::rec_pair_t           q_data
);

  localparam int PW = $clog2(MAX_LINE + 1);
  localparam int TW = $clog2(FIELD_LIMIT + 1);
  localparam int CW = (TW > csvt_pkg::MAXF_W) ? TW : csvt_pkg::MAXF_W;

  csvt_pkg::phase_t                phase_r, phase_nxt;
  csvt_pkg::cause_t                fail_r, fail_nxt;
  logic [PW-1:0]                   pos_r, pos_nxt;
  logic [PW-1:0]                   start_r, start_nxt;
  logic [TW-1:0]                   tally_r, tally_nxt;
  logic [csvt_pkg::MAXF_W-1:0]     maxf_r;

  logic [CW-1:0]                   maxf_ext;
  logic [CW-1:0]                   cap;
  logic                            cap_full;
  logic [TW:0]                     tally_inc;
  logic                            is_quote;
  logic                            is_comma;
  logic                            accept;

  logic                            fld_v;
  logic [PW-1:0]                   fb;
  logic [PW-1:0]                   fe;
  logic                            fq;
  logic                            sts_v;

  assign maxf_ext  = CW'(maxf_r);
  assign cap       = (maxf_ext > CW'(FIELD_LIMIT)) ? CW'(FIELD_LIMIT) : maxf_ext;
  assign cap_full  = CW'(tally_r) >= cap;
  assign tally_inc = {1'b0, tally_r} + (TW+1)'(1);
  assign is_quote  = in_char == csvt_pkg::CHAR_QUOTE;
  assign is_comma  = in_char == csvt_pkg::CHAR_COMMA;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    phase_nxt = phase_r;
    fail_nxt  = fail_r;
    pos_nxt   = pos_r;
    start_nxt = start_r;
    tally_nxt = tally_r;
    fld_v     = 1'b0;
    fb        = '0;
    fe        = '0;
    fq        = 1'b0;
    sts_v     = 1'b0;
    if (!in_mode) begin
      if (phase_r != csvt_pkg::PH_FAILED) begin
        if (pos_r >= PW'(MAX_LINE)) begin
          phase_nxt = csvt_pkg::PH_FAILED;
          fail_nxt  = csvt_pkg::CAUSE_TOO_LONG;
        end else begin
          unique case (phase_r)
            csvt_pkg::PH_LINE_START, csvt_pkg::PH_FIELD_START: begin
              if (cap_full) begin
                phase_nxt = csvt_pkg::PH_FAILED;
                fail_nxt  = csvt_pkg::CAUSE_CAPACITY;
              end else begin
                start_nxt = pos_r;
                if (is_quote) begin
                  start_nxt = pos_r + PW'(1);
                  phase_nxt = csvt_pkg::PH_QUOTED;
                end else if (is_comma) begin
                  fld_v     = 1'b1;
                  fb        = pos_r;
                  fe        = pos_r;
                  phase_nxt = csvt_pkg::PH_FIELD_START;
                end else begin
                  phase_nxt = csvt_pkg::PH_UNQUOTED;
                end
              end
            end
            csvt_pkg::PH_UNQUOTED: begin
              if (is_comma) begin
                fld_v     = 1'b1;
                fb        = start_r;
                fe        = pos_r;
                phase_nxt = csvt_pkg::PH_FIELD_START;
              end else if (is_quote) begin
                phase_nxt = csvt_pkg::PH_FAILED;
                fail_nxt  = csvt_pkg::CAUSE_STRAY;
              end
            end
            csvt_pkg::PH_QUOTED: begin
              if (is_quote) begin
                phase_nxt = csvt_pkg::PH_QUOTE_SEEN;
              end
            end
            csvt_pkg::PH_QUOTE_SEEN: begin
              if (is_quote) begin
                phase_nxt = csvt_pkg::PH_QUOTED;
              end else if (is_comma) begin
                fld_v     = 1'b1;
                fb        = start_r;
                fe        = pos_r - PW'(1);
                fq        = 1'b1;
                phase_nxt = csvt_pkg::PH_FIELD_START;
              end else begin
                phase_nxt = csvt_pkg::PH_FAILED;
                fail_nxt  = csvt_pkg::CAUSE_JUNK;
              end
            end
            default: begin
            end
          endcase
          if (phase_nxt != csvt_pkg::PH_FAILED) begin
            pos_nxt = pos_r + PW'(1);
          end
        end
      end
      if (fld_v) begin
        tally_nxt = tally_inc[TW-1:0];
      end
    end else begin
      // End of line: close the open field, then report line status
      unique case (phase_r)
        csvt_pkg::PH_LINE_START: begin
          if (cap_full) begin
            phase_nxt = csvt_pkg::PH_FAILED;
            fail_nxt  = csvt_pkg::CAUSE_CAPACITY;
          end else begin
            fld_v = 1'b1;
          end
        end
        csvt_pkg::PH_UNQUOTED: begin
          fld_v = 1'b1;
          fb    = start_r;
          fe    = pos_r;
        end
        csvt_pkg::PH_QUOTED: begin
          phase_nxt = csvt_pkg::PH_FAILED;
          fail_nxt  = csvt_pkg::CAUSE_UNTERMINATED;
        end
        csvt_pkg::PH_QUOTE_SEEN: begin
          fld_v = 1'b1;
          fb    = start_r;
          fe    = pos_r - PW'(1);
          fq    = 1'b1;
        end
        default: begin
        end
      endcase
      sts_v     = 1'b1;
      phase_nxt = csvt_pkg::PH_LINE_START;
      fail_nxt  = csvt_pkg::CAUSE_NONE;
      pos_nxt   = '0;
      start_nxt = '0;
      tally_nxt = '0;
    end
  end

  always_comb begin
    q_data.fld_v  = fld_v;
    q_data.fidx   = csvt_pkg::IDX_W'(tally_r);
    q_data.fbegin = csvt_pkg::OFS_W'(fb);
    q_data.fend   = csvt_pkg::OFS_W'(fe);
    q_data.quoted = fq;
    q_data.fcnt   = csvt_pkg::CNT_W'(tally_inc);
    q_data.sts_v  = sts_v;
    q_data.scnt   = fld_v ? csvt_pkg::CNT_W'(tally_inc) : csvt_pkg::CNT_W'(tally_r);
    // Failure is known either from earlier bytes or from the line end itself
    if (phase_r == csvt_pkg::PH_FAILED) begin
      q_data.kind  = csvt_pkg::KIND_REJECT;
      q_data.cause = fail_r;
    end else if (phase_r == csvt_pkg::PH_QUOTED) begin
      q_data.kind  = csvt_pkg::KIND_REJECT;
      q_data.cause = csvt_pkg::CAUSE_UNTERMINATED;
    end else if (phase_r == csvt_pkg::PH_LINE_START && cap_full) begin
      q_data.kind  = csvt_pkg::KIND_REJECT;
      q_data.cause = csvt_pkg::CAUSE_CAPACITY;
    end else begin
      q_data.kind  = csvt_pkg::KIND_ACCEPT;
      q_data.cause = csvt_pkg::CAUSE_NONE;
    end
  end

  assign q_push = accept && (fld_v || sts_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csvt_pkg::PH_LINE_START;
      fail_r  <= csvt_pkg::CAUSE_NONE;
      pos_r   <= '0;
      start_r <= '0;
      tally_r <= '0;
      maxf_r  <= csvt_pkg::MAXF_RESET;
    end else begin
      if (accept) begin
        phase_r <= phase_nxt;
        fail_r  <= fail_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        tally_r <= tally_nxt;
      end
      if (cfg_we) begin
        maxf_r <= cfg_data;
      end
    end
  end

endmodule

### rtl/csvt_queue.sv
// ----------------------------------------------------------------------------
// csvt_queue
// Small FIFO of record pairs between the parser and the output sequencer.
// ----------------------------------------------------------------------------
module csvt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  csvt_pkg::rec_pair_t push_data,
  input  logic                pop,
  output csvt_pkg::rec_pair_t head,
  output logic                full,
  output logic                empty
);

  csvt_pkg::rec_pair_t              mem_r [csvt_pkg::QUEUE_DEPTH];
  logic [csvt_pkg::QPTR_W-1:0]      wp_r;
  logic [csvt_pkg::QPTR_W-1:0]      rp_r;
  logic [csvt_pkg::QPTR_W:0]        cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign full    = cnt_r == (csvt_pkg::QPTR_W+1)'(csvt_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= wp_r + csvt_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + csvt_pkg::QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + (csvt_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (csvt_pkg::QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/csvt_back.sv
// ----------------------------------------------------------------------------
// csvt_back
// Output sequencer: holds one record pair and presents its field record and
// then its status record, one transfer each.
// ----------------------------------------------------------------------------
module csvt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  csvt_pkg::rec_pair_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output csvt_pkg::out_rec_t  out_rec
);

  csvt_pkg::rec_pair_t cur_r;
  logic                cur_v_r;
  logic                fld_pend_r;
  logic                step;
  logic                done;

  assign out_valid = cur_v_r;
  assign step      = cur_v_r && out_ready;
  assign done      = step && !(fld_pend_r && cur_r.sts_v);
  assign pop       = (!cur_v_r || done) && !empty;

  always_comb begin
    if (fld_pend_r) begin
      out_rec.kind   = csvt_pkg::KIND_FIELD;
      out_rec.fidx   = cur_r.fidx;
      out_rec.fbegin = cur_r.fbegin;
      out_rec.fend   = cur_r.fend;
      out_rec.quoted = cur_r.quoted;
      out_rec.cnt    = cur_r.fcnt;
      out_rec.cause  = csvt_pkg::CAUSE_NONE;
      out_rec.last   = !cur_r.sts_v;
    end else begin
      out_rec.kind   = cur_r.kind;
      out_rec.fidx   = '0;
      out_rec.fbegin = '0;
      out_rec.fend   = '0;
      out_rec.quoted = 1'b0;
      out_rec.cnt    = cur_r.scnt;
      out_rec.cause  = cur_r.cause;
      out_rec.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r    <= 1'b0;
      fld_pend_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_v_r    <= 1'b1;
        fld_pend_r <= head.fld_v;
      end else if (done) begin
        cur_v_r    <= 1'b0;
        fld_pend_r <= 1'b0;
      end else if (step) begin
        // field went out, status still to come
        fld_pend_r <= 1'b0;
      end
    end
  end

  a_pop_has_record: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (head.fld_v || head.sts_v))
    else $error("queue entry carries no record");

  a_status_present: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_v_r && !fld_pend_r) |-> cur_r.sts_v)
    else $error("status shown for an entry without one");

  a_field_pending_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fld_pend_r |-> (cur_v_r && cur_r.fld_v))
    else $error("field pending without a field record");

  a_split_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (step && fld_pend_r && cur_r.sts_v) |=> (cur_v_r && !fld_pend_r))
    else $error("status record of a pair was lost");

endmodule

### rtl/csvt_out_if_unused_guard.sv
// ----------------------------------------------------------------------------
// csvt_ovf_chk
// Port-side check of the result channel: a status record always closes the
// records caused by one item, and only reject records carry a cause.
// ----------------------------------------------------------------------------
module csvt_ovf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [1:0] out_kind,
  input logic       out_last,
  input logic [2:0] out_cause
);

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != csvt_pkg::KIND_FIELD) |-> out_last)
    else $error("status record not marked last");

  a_accept_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != csvt_pkg::KIND_REJECT) |-> out_cause == csvt_pkg::CAUSE_NONE)
    else $error("cause set on a non-reject record");

  a_reject_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == csvt_pkg::KIND_REJECT) |-> out_cause != csvt_pkg::CAUSE_NONE)
    else $error("reject record without a cause");

endmodule

### rtl/csv_line_field_tokenizer_unit.sv
// A result passes through the record queue and the output sequencer's register
// before it is offered. One item is taken per cycle while the queue is not
// full; an item with both a field and a line status needs two transfers from
// the single output sequencer; a 4-entry queue absorbs the difference.
// Reset (synchronous, rst_n low): parser at line start, queue empty, no result
// offered, max_fields back to 64. No clearing pass.
// ----------------------------------------------------------------------------
// csv_line_field_tokenizer_unit
// CSV line tokenizer with quoted fields: parser front end, record queue and
// output sequencer.
// ----------------------------------------------------------------------------
module csv_line_field_tokenizer_unit #(
  parameter int MAX_LINE    = 4096,
  parameter int FIELD_LIMIT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csvt_in_if.sink                     in_ch,
  csvt_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [csvt_pkg::MAXF_W-1:0] cfg_data
);

  csvt_pkg::rec_pair_t q_data;
  csvt_pkg::rec_pair_t q_head;
  csvt_pkg::out_rec_t  out_rec;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic                in_ready;
  logic                out_valid;

  csvt_front #(
    .MAX_LINE    (MAX_LINE),
    .FIELD_LIMIT (FIELD_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_mode  (in_ch.mode),
    .in_char  (in_ch.char_byte),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  csvt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  csvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_rec   (out_rec)
  );

  csvt_ovf_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_kind  (out_rec.kind),
    .out_last  (out_rec.last),
    .out_cause (out_rec.cause)
  );

  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.record_kind    = out_rec.kind;
  assign out_ch.field_index    = out_rec.fidx;
  assign out_ch.field_begin    = out_rec.fbegin;
  assign out_ch.field_end      = out_rec.fend;
  assign out_ch.field_quoted   = out_rec.quoted;
  assign out_ch.fields_in_line = out_rec.cnt;
  assign out_ch.error_cause    = out_rec.cause;
  assign out_ch.last_of_run    = out_rec.last;

endmodule
